// ----- rtl/rkct_pkg.sv -----
// shared types and codes for the render kick completion tracker
package rkct_pkg;

    // item action codes
    typedef enum logic [1:0] {
        ACT_ARM     = 2'd0,
        ACT_POLL    = 2'd1,
        ACT_SERVICE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // write-one-to-clear mask bit positions
    localparam int unsigned CLR_OOM   = 0;
    localparam int unsigned CLR_FLUSH = 1;
    localparam int unsigned CLR_FRAME = 2;

    // register indexes
    localparam logic REG_OVERFLOW_ADDR  = 1'b0;
    localparam logic REG_OVERFLOW_BYTES = 1'b1;

    // low byte mask of the hardware counters
    localparam logic [31:0] LOW_BYTE = 32'h0000_00ff;

    typedef struct packed {
        logic [31:0] overflow_addr;
        logic [31:0] overflow_bytes;
    } cfg_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] start_addr;
        logic [31:0] end_addr;
        logic [31:0] target_seqno;
        logic [7:0]  bin_count;
        logic [7:0]  render_count;
        logic        binner_running;
        logic        renderer_running;
        logic        flush_done;
        logic        frame_done;
        logic        out_of_memory;
        logic        oom_level;
    } item_t;

    typedef struct packed {
        logic        kick_valid;
        logic [31:0] kick_start;
        logic [31:0] kick_end;
        logic        kick_deferred;
        logic        feed_valid;
        logic [31:0] feed_addr;
        logic [31:0] feed_size;
        logic        overflow_exhausted;
        logic [31:0] done_seqno;
        logic [2:0]  clear_mask;
    } result_t;

endpackage

// ----- rtl/render_kick_completion_tracker.sv -----
// top level of the render kick completion tracker
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | in        | in_valid / in_stall  | action .. oom_level
//  out     | out       | out_valid / out_stall| kick_valid .. clear_mask
//  apb     | in        | psel/penable/pready  | paddr, pwdata, prdata
//
// one beat per cycle sustained while out_stall is low; an accepted beat passes
// through the input register and then the result register
// the per-beat update is a pair of 32-bit adds and compares on the job state
// reset clears the apb registers, the job state and both valid flags, not the payload registers
// out_stall holds the result register and backs up through the input register
module render_kick_completion_tracker
    import rkct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] start_addr,
    input  logic [31:0] end_addr,
    input  logic [31:0] target_seqno,
    input  logic [7:0]  bin_count,
    input  logic [7:0]  render_count,
    input  logic        binner_running,
    input  logic        renderer_running,
    input  logic        flush_done,
    input  logic        frame_done,
    input  logic        out_of_memory,
    input  logic        oom_level,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        kick_valid,
    output logic [31:0] kick_start,
    output logic [31:0] kick_end,
    output logic        kick_deferred,
    output logic        feed_valid,
    output logic [31:0] feed_addr,
    output logic [31:0] feed_size,
    output logic        overflow_exhausted,
    output logic [31:0] done_seqno,
    output logic [2:0]  clear_mask
);

    cfg_t    cfg;
    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    take;
    result_t result;

    // gather the input beat
    always_comb
    begin
        in_item.action           = action_t'(action);
        in_item.start_addr       = start_addr;
        in_item.end_addr         = end_addr;
        in_item.target_seqno     = target_seqno;
        in_item.bin_count        = bin_count;
        in_item.render_count     = render_count;
        in_item.binner_running   = binner_running;
        in_item.renderer_running = renderer_running;
        in_item.flush_done       = flush_done;
        in_item.frame_done       = frame_done;
        in_item.out_of_memory    = out_of_memory;
        in_item.oom_level        = oom_level;
    end

    rkct_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rkct_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .in_stall   (in_stall),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    rkct_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .held_valid (held_valid),
        .held_item  (held_item),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    // spread the result beat onto its ports
    assign kick_valid         = result.kick_valid;
    assign kick_start         = result.kick_start;
    assign kick_end           = result.kick_end;
    assign kick_deferred      = result.kick_deferred;
    assign feed_valid         = result.feed_valid;
    assign feed_addr          = result.feed_addr;
    assign feed_size          = result.feed_size;
    assign overflow_exhausted = result.overflow_exhausted;
    assign done_seqno         = result.done_seqno;
    assign clear_mask         = result.clear_mask;

endmodule

// ----- rtl/rkct_apb_regs.sv -----
// apb register file holding the overspill buffer address and size
module rkct_apb_regs
    import rkct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;
    logic sel;

    assign pready = 1'b1;
    assign sel    = paddr[2];
    assign wr_en  = psel && penable && pwrite;

    // register writes on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_OVERFLOW_ADDR:  cfg_reg.overflow_addr  <= pwdata;
                REG_OVERFLOW_BYTES: cfg_reg.overflow_bytes <= pwdata;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (sel)
            REG_OVERFLOW_ADDR:  prdata = cfg_reg.overflow_addr;
            REG_OVERFLOW_BYTES: prdata = cfg_reg.overflow_bytes;
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/rkct_in_stage.sv -----
// input register that holds one beat until the step logic takes it
module rkct_in_stage
    import rkct_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  in_stall,
    input  logic  take,
    output logic  held_valid,
    output item_t held_item
);

    logic  held_valid_reg;
    logic  held_valid_next;
    item_t held_item_reg;
    logic  load;

    // free when empty or when the held beat moves on this cycle
    assign in_stall = held_valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (take)
        begin
            held_valid_next = 1'b0;
        end
        if (load)
        begin
            held_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_item_reg <= in_item;
        end
    end

    assign held_valid = held_valid_reg;
    assign held_item  = held_item_reg;

endmodule

// ----- rtl/rkct_step.sv -----
// job state, per-beat update logic and the result register
module rkct_step
    import rkct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    held_valid,
    input  item_t   held_item,
    output logic    take,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t result
);

    typedef enum logic [1:0] {
        OVF_IDLE      = 2'd0,
        OVF_HANDED    = 2'd1,
        OVF_EXHAUSTED = 2'd2
    } ovf_stage_t;

    logic        render_pending_reg, render_pending_next;
    logic [31:0] held_start_reg, held_start_next;
    logic [31:0] held_end_reg, held_end_next;
    logic [31:0] want_seqno_reg, want_seqno_next;
    logic [7:0]  prev_bin_reg, prev_bin_next;
    logic [7:0]  prev_render_reg, prev_render_next;
    logic [31:0] bin_total_reg, bin_total_next;
    logic [31:0] render_total_reg, render_total_next;
    logic [31:0] finished_reg, finished_next;
    ovf_stage_t  ovf_stage_reg, ovf_stage_next;

    logic        out_valid_reg;
    result_t     result_reg, result_next;

    logic [7:0]  bin_delta;
    logic [7:0]  ren_delta;
    logic [31:0] bin_sum;
    logic [31:0] ren_sum;
    logic [31:0] ren_final;
    logic        kick_want;
    logic        kick_go;
    logic        resync;

    // the held beat moves when the result register is free or draining
    assign take = held_valid && (!out_valid_reg || !out_stall);

    // counter deltas modulo 256
    assign bin_delta = held_item.bin_count - prev_bin_reg;
    assign ren_delta = held_item.render_count - prev_render_reg;
    assign bin_sum   = bin_total_reg + {24'd0, bin_delta};
    assign ren_sum   = render_total_reg + {24'd0, ren_delta};

    // kick request for poll (bin total reached) or service (flush done)
    always_comb
    begin
        case (held_item.action)
            ACT_POLL:    kick_want = render_pending_reg && (bin_sum >= want_seqno_reg);
            ACT_SERVICE: kick_want = render_pending_reg && held_item.flush_done;
            default:     kick_want = 1'b0;
        endcase
    end
    assign kick_go = kick_want && !held_item.renderer_running;

    // resync when idle, the render total is below the target and the render counter low byte matches it
    assign resync = !kick_go && (ren_sum < want_seqno_reg) && !render_pending_reg
                    && (held_item.render_count == want_seqno_reg[7:0])
                    && !held_item.binner_running && !held_item.renderer_running;
    assign ren_final = resync ? want_seqno_reg : ren_sum;

    // next state and result
    always_comb
    begin
        render_pending_next = render_pending_reg;
        held_start_next     = held_start_reg;
        held_end_next       = held_end_reg;
        want_seqno_next     = want_seqno_reg;
        prev_bin_next       = prev_bin_reg;
        prev_render_next    = prev_render_reg;
        bin_total_next      = bin_total_reg;
        render_total_next   = render_total_reg;
        finished_next       = finished_reg;
        ovf_stage_next      = ovf_stage_reg;
        result_next         = '0;

        if (kick_want)
        begin
            result_next.kick_deferred = !kick_go;
        end
        if (kick_go)
        begin
            render_pending_next    = 1'b0;
            result_next.kick_valid = 1'b1;
            result_next.kick_start = held_start_reg;
            result_next.kick_end   = held_end_reg;
        end

        case (held_item.action)
            ACT_ARM:
            begin
                held_start_next     = held_item.start_addr;
                held_end_next       = held_item.end_addr;
                want_seqno_next     = held_item.target_seqno;
                render_pending_next = 1'b1;
                ovf_stage_next      = OVF_IDLE;
            end
            ACT_POLL:
            begin
                prev_bin_next     = held_item.bin_count;
                prev_render_next  = held_item.render_count;
                bin_total_next    = resync ? want_seqno_reg : bin_sum;
                render_total_next = ren_final;
                finished_next     = (ren_final > want_seqno_reg) ? want_seqno_reg : ren_final;
            end
            ACT_SERVICE:
            begin
                if (held_item.out_of_memory || held_item.oom_level)
                begin
                    if (ovf_stage_reg == OVF_IDLE && cfg.overflow_addr != '0)
                    begin
                        ovf_stage_next         = OVF_HANDED;
                        result_next.feed_valid = 1'b1;
                        result_next.feed_addr  = cfg.overflow_addr;
                        result_next.feed_size  = cfg.overflow_bytes;
                    end
                    else if (ovf_stage_reg == OVF_HANDED)
                    begin
                        ovf_stage_next                 = OVF_EXHAUSTED;
                        result_next.overflow_exhausted = 1'b1;
                    end
                end
                result_next.clear_mask[CLR_OOM]   = held_item.out_of_memory;
                result_next.clear_mask[CLR_FLUSH] = held_item.flush_done;
                result_next.clear_mask[CLR_FRAME] = held_item.frame_done;
            end
            default:
            begin
                render_pending_next = render_pending_reg;
            end
        endcase

        result_next.done_seqno = finished_next;
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            render_pending_reg <= 1'b0;
            held_start_reg     <= '0;
            held_end_reg       <= '0;
            want_seqno_reg     <= '0;
            prev_bin_reg       <= '0;
            prev_render_reg    <= '0;
            bin_total_reg      <= '0;
            render_total_reg   <= '0;
            finished_reg       <= '0;
            ovf_stage_reg      <= OVF_IDLE;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                render_pending_reg <= render_pending_next;
                held_start_reg     <= held_start_next;
                held_end_reg       <= held_end_next;
                want_seqno_reg     <= want_seqno_next;
                prev_bin_reg       <= prev_bin_next;
                prev_render_reg    <= prev_render_next;
                bin_total_reg      <= bin_total_next;
                render_total_reg   <= render_total_next;
                finished_reg       <= finished_next;
                ovf_stage_reg      <= ovf_stage_next;
                out_valid_reg      <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ----- rtl/rkct_checker.sv -----
// port-level checks for the render kick completion tracker, bound to the top
module rkct_checker
    import rkct_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        kick_valid,
    input logic [31:0] kick_start,
    input logic [31:0] kick_end,
    input logic        kick_deferred,
    input logic        feed_valid,
    input logic [31:0] feed_addr,
    input logic        overflow_exhausted,
    input logic [31:0] done_seqno
);

    // a stalled result beat stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(done_seqno) && $stable(kick_valid))
        else $error("result beat changed under stall");

    // a kick is either issued or deferred, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(kick_valid && kick_deferred))
        else $error("kick issued and deferred together");

    // no kick means zero addresses
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kick_valid |-> kick_start == '0 && kick_end == '0)
        else $error("kick addresses without a kick");

    // a feed carries a real buffer and never coincides with exhaustion
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && feed_valid |-> feed_addr != '0 && !overflow_exhausted)
        else $error("bad overspill feed");

endmodule

bind render_kick_completion_tracker rkct_checker u_rkct_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .kick_valid         (kick_valid),
    .kick_start         (kick_start),
    .kick_end           (kick_end),
    .kick_deferred      (kick_deferred),
    .feed_valid         (feed_valid),
    .feed_addr          (feed_addr),
    .overflow_exhausted (overflow_exhausted),
    .done_seqno         (done_seqno)
);
